// ----- sv/free_look_camera_update_core_assert.svh -----
// Assertion macros shared by the camera update RTL.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef FREE_LOOK_CAMERA_UPDATE_CORE_ASSERT_SVH
`define FREE_LOOK_CAMERA_UPDATE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define FLCU_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that must hold whenever the antecedent holds.
`define FLCU_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/flcu_pkg.sv -----
// Package for the camera update block: constants, the arctangent table and
// rounding helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package flcu_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MOVE_SPEED = 2'd0;
	localparam logic [1:0] CFG_MOUSE_SENS = 2'd1;

	localparam int ONE_Q14    = 16384;
	localparam int ANG_90     = 90 * 65536;
	localparam int ANG_HALF   = 180 * 65536;
	localparam int ANG_FULL   = 360 * 65536;
	localparam int PITCH_LIM  = 89 * 65536;
	localparam int GAIN_INV_Q30 = 652032875;
	localparam int MOVE_RESET = 163840;
	localparam int SENS_RESET = 6554;

	// 128 full turns, added so that the yaw sum is never negative.
	localparam logic [33:0] WRAP_BIAS = 34'd3019898880;

	localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] POS_MIN = 32'sh80000000;

	// Status and results of the trigonometry unit.
	typedef struct packed {
		logic               busy;
		logic               done;
		logic signed [15:0] cos_v;
		logic signed [15:0] sin_v;
	} flcu_trig_t;

	// Arctangent of 2^-i in degrees, Q16.
	function automatic logic [21:0] atan_deg_q16(input logic [4:0] idx);
		logic [21:0] r;
		case (idx)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117305;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

	// Clamp a wider value to the unit range of Q1.14.
	function automatic logic signed [15:0] clamp_q14(input logic signed [27:0] v);
		logic signed [15:0] r;
		if (v > 28'sd16384)
			r = 16'sd16384;
		else if (v < -28'sd16384)
			r = -16'sd16384;
		else
			r = 16'(v);
		return r;
	endfunction

	// Q1.30 to Q1.14, rounded half up, optionally negated, clamped.
	function automatic logic signed [15:0] q30_to_q14(input logic signed [33:0] v,
			input logic neg);
		logic signed [33:0] t;
		logic signed [27:0] r;
		t = (v + 34'sd32768) >>> 16;
		r = neg ? -28'(t) : 28'(t);
		return clamp_q14(r);
	endfunction

	// Product of two Q1.14 values back to Q1.14, rounded half up, clamped.
	function automatic logic signed [15:0] mul_round_q14(input logic signed [41:0] p);
		logic signed [41:0] t;
		t = (p + 42'sd8192) >>> 14;
		return clamp_q14(28'(t));
	endfunction

endpackage

`default_nettype wire

// ----- sv/flcu_cordic.sv -----
// Iterative rotation-mode CORDIC: cosine and sine of an angle in Q16 degrees.
// Depends on flcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flcu_cordic #(
	parameter int STEPS = flcu_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [25:0] angle,
	output flcu_pkg::flcu_trig_t    trig
);
	import flcu_pkg::*;

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic               busy_q;
	logic               done_q;
	logic               flip_q;
	logic [IW-1:0]      i_q;
	logic signed [33:0] x_q;
	logic signed [33:0] y_q;
	logic signed [25:0] z_q;

	logic signed [33:0] dx;
	logic signed [33:0] dy;
	logic signed [25:0] at;

	// One micro-rotation per cycle through a shared shifter and adders.
	always_comb begin
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		at = 26'(atan_deg_q16(5'(i_q)));
	end

	// Control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && i_q == IW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Rotation datapath; angles beyond a right angle fold by a half turn.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= 34'(GAIN_INV_Q30);
			y_q <= '0;
			i_q <= '0;
			if (angle > 26'(ANG_90)) begin
				z_q    <= angle - 26'(ANG_HALF);
				flip_q <= 1'b1;
			end else if (angle < -26'(ANG_90)) begin
				z_q    <= angle + 26'(ANG_HALF);
				flip_q <= 1'b1;
			end else begin
				z_q    <= angle;
				flip_q <= 1'b0;
			end
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign trig.busy  = busy_q;
	assign trig.done  = done_q;
	assign trig.cos_v = q30_to_q14(x_q, flip_q);
	assign trig.sin_v = q30_to_q14(y_q, flip_q);

endmodule

`default_nettype wire

// ----- sv/free_look_camera_update_core.sv -----
// Top level of the fly camera update block: sequencer, shared multiplier,
// camera state. Depends on flcu_pkg, flcu_cordic and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a saturating Q16.16 position, yaw and pitch in degrees and
// the front, right and up vectors in Q1.14, and returns the full state once
// per item. One item is worked at a time; in_stall stays high until the
// sequencer is back in idle. A movement tick forms each position step for
// every held key with one 25x17 multiplier in two partial products. A mouse
// item runs the single iterative CORDIC unit once for yaw and once for
// pitch, with an eight-step yaw wrap and six multiplies. The result sits in
// an output register, so the next item is taken while it waits. Configuration
// writes are always ready; unknown register indexes are ignored.
module free_look_camera_update_core #(
	parameter int CORDIC_STEPS = flcu_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [5:0]         key_mask,
	input  wire logic [15:0]        delta_time,
	input  wire logic signed [23:0] mouse_dx,
	input  wire logic signed [23:0] mouse_dy,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [15:0]      front_x,
	output logic signed [15:0]      front_y,
	output logic signed [15:0]      front_z,
	output logic signed [15:0]      right_x,
	output logic signed [15:0]      right_y,
	output logic signed [15:0]      right_z,
	output logic signed [15:0]      up_x,
	output logic signed [15:0]      up_y,
	output logic signed [15:0]      up_z,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [23:0]        cfg_data
);
	import flcu_pkg::*;

	typedef enum logic [20:0] {
		S_IDLE   = 21'h000001,
		S_DIST   = 21'h000002,
		S_DIST2  = 21'h000004,
		S_KEY    = 21'h000008,
		S_LO     = 21'h000010,
		S_HI     = 21'h000020,
		S_ADD    = 21'h000040,
		S_DYAW   = 21'h000080,
		S_DPITCH = 21'h000100,
		S_WINIT  = 21'h000200,
		S_WRAP   = 21'h000400,
		S_CYS    = 21'h000800,
		S_CYW    = 21'h001000,
		S_CPS    = 21'h002000,
		S_CPW    = 21'h004000,
		S_V0     = 21'h008000,
		S_V1     = 21'h010000,
		S_V2     = 21'h020000,
		S_V3     = 21'h040000,
		S_V4     = 21'h080000,
		S_OUT    = 21'h100000
	} flcu_state_t;

	flcu_state_t        state_q;
	logic               out_valid_q;
	logic [23:0]        speed_q;
	logic [15:0]        sens_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] front_q [3];
	logic signed [15:0] right_q [3];
	logic signed [15:0] up_q [3];
	logic signed [25:0] yaw_q;
	logic signed [23:0] pitch_q;
	logic [2:0]         key_idx_q;
	logic [1:0]         coord_q;
	logic [2:0]         wrap_k_q;
	logic [33:0]        wrap_q;

	// Payload registers.
	logic               req_q;
	logic [5:0]         keys_q;
	logic [15:0]        dt_q;
	logic signed [23:0] dx_q;
	logic signed [23:0] dy_q;
	logic [39:0]        dist_q;
	logic signed [41:0] prod_q;
	logic signed [41:0] acc_q;
	logic signed [33:0] dyaw_q;
	logic signed [15:0] cy_q;
	logic signed [15:0] sy_q;
	logic signed [15:0] cp_q;
	logic signed [15:0] sp_q;
	logic signed [31:0] out_pos_q [3];
	logic signed [15:0] out_front_q [3];
	logic signed [15:0] out_right_q [3];
	logic signed [15:0] out_up_q [3];

	logic               in_xfer;
	logic               out_load;
	logic signed [24:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [15:0] v_raw;
	logic signed [16:0] v_sel;
	logic signed [56:0] mv_full;
	logic signed [56:0] mv_step;
	logic signed [33:0] mv_sum;
	logic signed [31:0] mv_sat;
	logic signed [33:0] dpitch;
	logic signed [34:0] pitch_sum;
	logic [33:0]        wrap_cmp;
	logic [33:0]        wrap_nx;
	logic               cordic_start;
	logic signed [25:0] cordic_angle;
	flcu_trig_t         trig;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	// Direction vector component for the current key, with its sign.
	always_comb begin
		case (key_idx_q)
			3'd0, 3'd1: v_raw = front_q[coord_q];
			3'd2, 3'd3: v_raw = right_q[coord_q];
			default:    v_raw = up_q[coord_q];
		endcase
		if (key_idx_q == 3'd1 || key_idx_q == 3'd2 || key_idx_q == 3'd5)
			v_sel = -17'(v_raw);
		else
			v_sel = 17'(v_raw);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_DIST: begin
				mul_a = 25'({1'b0, speed_q});
				mul_b = 17'({1'b0, dt_q});
			end
			S_LO: begin
				mul_a = 25'({1'b0, dist_q[19:0]});
				mul_b = v_sel;
			end
			S_HI: begin
				mul_a = 25'({1'b0, dist_q[39:20]});
				mul_b = v_sel;
			end
			S_DYAW: begin
				mul_a = 25'(dx_q);
				mul_b = 17'({1'b0, sens_q});
			end
			S_DPITCH: begin
				mul_a = 25'(dy_q);
				mul_b = 17'({1'b0, sens_q});
			end
			S_V0: begin
				mul_a = 25'(cy_q);
				mul_b = 17'(cp_q);
			end
			S_V1: begin
				mul_a = 25'(sy_q);
				mul_b = 17'(cp_q);
			end
			S_V2: begin
				mul_a = 25'(cy_q);
				mul_b = 17'(sp_q);
			end
			S_V3: begin
				mul_a = 25'(sy_q);
				mul_b = 17'(sp_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Position step: join the partial products, round, saturate.
	always_comb begin
		mv_full = 57'(acc_q) + (57'(prod_q) <<< 20) + 57'(32'sd536870912);
		mv_step = mv_full >>> 30;
		mv_sum  = 34'(pos_q[coord_q]) + 34'(mv_step);
		if (mv_sum > 34'(POS_MAX))
			mv_sat = POS_MAX;
		else if (mv_sum < 34'(POS_MIN))
			mv_sat = POS_MIN;
		else
			mv_sat = 32'(mv_sum);
	end

	// Pitch update and one restoring step of the yaw wrap.
	always_comb begin
		dpitch    = 34'((prod_q + 42'sd128) >>> 8);
		pitch_sum = 35'(pitch_q) + 35'(dpitch);
		wrap_cmp  = 34'(ANG_FULL) << wrap_k_q;
		wrap_nx   = (wrap_q >= wrap_cmp) ? (wrap_q - wrap_cmp) : wrap_q;
	end

	assign cordic_start = (state_q == S_CYS) || (state_q == S_CPS);
	assign cordic_angle = (state_q == S_CYS) ? yaw_q : 26'(pitch_q);

	flcu_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.angle  (cordic_angle),
		.trig   (trig)
	);

	// Sequencer, configuration and camera state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			speed_q     <= 24'(MOVE_RESET);
			sens_q      <= 16'(SENS_RESET);
			pos_q       <= '{default: '0};
			front_q     <= '{16'sd0, 16'sd0, -16'(ONE_Q14)};
			right_q     <= '{16'(ONE_Q14), 16'sd0, 16'sd0};
			up_q        <= '{16'sd0, 16'(ONE_Q14), 16'sd0};
			yaw_q       <= -26'(ANG_90);
			pitch_q     <= '0;
			key_idx_q   <= '0;
			coord_q     <= '0;
			wrap_k_q    <= '0;
			wrap_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MOVE_SPEED: speed_q <= cfg_data;
					CFG_MOUSE_SENS: sens_q  <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer)
						state_q <= req_type ? S_DYAW : S_DIST;
				end
				S_DIST: state_q <= S_DIST2;
				S_DIST2: begin
					key_idx_q <= '0;
					coord_q   <= '0;
					state_q   <= S_KEY;
				end
				S_KEY: begin
					if (key_idx_q == 3'd6) begin
						state_q <= S_OUT;
					end else if (keys_q[key_idx_q]) begin
						coord_q <= '0;
						state_q <= S_LO;
					end else begin
						key_idx_q <= key_idx_q + 1'b1;
					end
				end
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_ADD;
				S_ADD: begin
					pos_q[coord_q] <= mv_sat;
					if (coord_q == 2'd2) begin
						key_idx_q <= key_idx_q + 1'b1;
						state_q   <= S_KEY;
					end else begin
						coord_q <= coord_q + 1'b1;
						state_q <= S_LO;
					end
				end
				S_DYAW: state_q <= S_DPITCH;
				S_DPITCH: state_q <= S_WINIT;
				S_WINIT: begin
					if (pitch_sum > 35'(PITCH_LIM))
						pitch_q <= 24'(PITCH_LIM);
					else if (pitch_sum < -35'(PITCH_LIM))
						pitch_q <= -24'(PITCH_LIM);
					else
						pitch_q <= 24'(pitch_sum);
					wrap_q   <= 34'(36'(yaw_q) + 36'(dyaw_q) + 36'(ANG_HALF) + 36'(WRAP_BIAS));
					wrap_k_q <= 3'd7;
					state_q  <= S_WRAP;
				end
				S_WRAP: begin
					wrap_q <= wrap_nx;
					if (wrap_k_q == 3'd0) begin
						yaw_q   <= 26'($signed({1'b0, wrap_nx}) - 35'(ANG_HALF));
						state_q <= S_CYS;
					end else begin
						wrap_k_q <= wrap_k_q - 1'b1;
					end
				end
				S_CYS: state_q <= S_CYW;
				S_CYW: begin
					if (trig.done)
						state_q <= S_CPS;
				end
				S_CPS: state_q <= S_CPW;
				S_CPW: begin
					if (trig.done)
						state_q <= S_V0;
				end
				S_V0: state_q <= S_V1;
				S_V1: begin
					front_q[0] <= mul_round_q14(prod_q);
					state_q    <= S_V2;
				end
				S_V2: begin
					front_q[2] <= mul_round_q14(prod_q);
					state_q    <= S_V3;
				end
				S_V3: begin
					up_q[0] <= -mul_round_q14(prod_q);
					state_q <= S_V4;
				end
				S_V4: begin
					up_q[2]    <= -mul_round_q14(prod_q);
					up_q[1]    <= cp_q;
					front_q[1] <= sp_q;
					right_q[0] <= -sy_q;
					right_q[1] <= '0;
					right_q[2] <= cy_q;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload: captured item, multiplier pipeline, trig results, output buffer.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_xfer) begin
			req_q  <= req_type;
			keys_q <= key_mask;
			dt_q   <= delta_time;
			dx_q   <= mouse_dx;
			dy_q   <= mouse_dy;
		end
		if (state_q == S_DIST2)
			dist_q <= prod_q[39:0];
		if (state_q == S_HI)
			acc_q <= prod_q;
		if (state_q == S_DPITCH)
			dyaw_q <= 34'((prod_q + 42'sd128) >>> 8);
		if (state_q == S_CYW && trig.done) begin
			cy_q <= trig.cos_v;
			sy_q <= trig.sin_v;
		end
		if (state_q == S_CPW && trig.done) begin
			cp_q <= trig.cos_v;
			sp_q <= trig.sin_v;
		end
		if (out_load) begin
			out_pos_q   <= pos_q;
			out_front_q <= front_q;
			out_right_q <= right_q;
			out_up_q    <= up_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = out_pos_q[0];
	assign pos_y     = out_pos_q[1];
	assign pos_z     = out_pos_q[2];
	assign front_x   = out_front_q[0];
	assign front_y   = out_front_q[1];
	assign front_z   = out_front_q[2];
	assign right_x   = out_right_q[0];
	assign right_y   = out_right_q[1];
	assign right_z   = out_right_q[2];
	assign up_x      = out_up_q[0];
	assign up_y      = out_up_q[1];
	assign up_z      = out_up_q[2];

`include "free_look_camera_update_core_assert.svh"

	// The kind of the captured item decides the branch right after the transfer.
	`FLCU_ASSERT_IMPLY(a_branch, (state_q == S_DYAW) || (state_q == S_DIST), req_q == (state_q == S_DYAW), "item kind and sequencer branch disagree")
	`FLCU_ASSERT_ALWAYS(a_pitch_range, (pitch_q <= 24'(PITCH_LIM)) && (pitch_q >= -24'(PITCH_LIM)), "pitch left its clamp range")
	`FLCU_ASSERT_ALWAYS(a_yaw_range, (yaw_q >= -26'(ANG_HALF)) && (yaw_q < 26'(ANG_HALF)), "yaw left its wrap range")
	`FLCU_ASSERT_IMPLY(a_cordic_free, cordic_start, !trig.busy, "trig unit restarted while busy")
	`FLCU_ASSERT_IMPLY(a_out_src, $rose(out_valid_q), $past(state_q == S_OUT), "result shown without a finished item")

endmodule

`default_nettype wire
